FILE: src/baro_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared register indexes, widths and stage counts for the compensation unit.
// ----------------------------------------------------------------------------
package baro_pkg;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        REG_TEMP_COEFFS   = 8'd0,
        REG_PRES_COEFFS_A = 8'd1,
        REG_PRES_COEFFS_B = 8'd2,
        REG_PRES_COEFF_P9 = 8'd3
    } t_reg_idx;

    localparam int W = 32;
    // Stages ahead of the divider, divider steps, stages after it.
    localparam int PRE_STAGES  = 13;
    localparam int DIV_STAGES  = W;
    localparam int POST_STAGES = 3;
    localparam int NUM_STAGES  = PRE_STAGES + DIV_STAGES + POST_STAGES;

    localparam logic [W-1:0] TEMP_OFFSET = 32'd64000;
    localparam logic [W-1:0] FULL_SCALE  = 32'd1048576;
    localparam logic [W-1:0] PRES_SCALE  = 32'd3125;
    localparam logic [W-1:0] HALF_RANGE  = 32'h8000_0000;
    localparam logic [W-1:0] P1_BIAS     = 32'd32768;
    localparam logic [W-1:0] TEMP_ROUND  = 32'd128;

    // Sign-extend a 16-bit coefficient to a 32-bit word.
    function automatic logic [W-1:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // Arithmetic shift right of a 32-bit word.
    function automatic logic [W-1:0] asr(input logic [W-1:0] x, input int n);
        asr = W'($signed(x) >>> n);
    endfunction

endpackage

FILE: src/baro_temp_pressure_compensation_unit.sv
// Pipeline: 13 arithmetic stages, 32 divider stages, 3 correction stages and the
// output register lie between input request and result.
// Throughput: one request per cycle; the whole pipeline stalls as one while a
// result waits at the output. The restoring divider, one quotient bit per stage, sets depth.
// Reset (synchronous, active low) clears all valid bits and the calibration registers.
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation unit
// Applies the 32-bit integer compensation to raw 20-bit readings.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit
    import baro_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [19:0] raw_pressure, [39:20] raw_temperature
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [31:0] temperature_centi, [63:32] pressure_pa
    output logic        m_axis_tuser   // [0] pressure_invalid
);

    // Calibration registers.
    logic [47:0] r_tc;
    logic [63:0] r_pa, r_pb;
    logic [15:0] r_p9;

    logic [W-1:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tc[15:0]};
    assign t2 = sx16(r_tc[31:16]);
    assign t3 = sx16(r_tc[47:32]);
    assign p1 = {16'd0, r_pa[15:0]};
    assign p2 = sx16(r_pa[31:16]);
    assign p3 = sx16(r_pa[47:32]);
    assign p4 = sx16(r_pa[63:48]);
    assign p5 = sx16(r_pb[15:0]);
    assign p6 = sx16(r_pb[31:16]);
    assign p7 = sx16(r_pb[47:32]);
    assign p8 = sx16(r_pb[63:48]);
    assign p9 = sx16(r_p9);

    assign o_cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pa <= '0;
            r_pb <= '0;
            r_p9 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEMP_COEFFS:   r_tc <= i_cfg_data[47:0];
                REG_PRES_COEFFS_A: r_pa <= i_cfg_data;
                REG_PRES_COEFFS_B: r_pb <= i_cfg_data;
                REG_PRES_COEFF_P9: r_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves when the output register can take data.
    logic en;
    logic r_ov;
    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // Valid bits travel alongside the data.
    logic [NUM_STAGES-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STAGES-2:0], s_axis_tvalid};
            r_ov  <= r_vld[NUM_STAGES-1];
        end
    end

    logic [W-1:0] adc_p, adc_t;
    assign adc_p = {12'd0, s_axis_tdata[19:0]};
    assign adc_t = {12'd0, s_axis_tdata[39:20]};

    // Pre-division stage registers.
    logic [W-1:0] r1_x, r1_d, r1_p;
    logic [W-1:0] r2_m, r2_dd, r2_p;
    logic [W-1:0] r3_a, r3_e, r3_p;
    logic [W-1:0] r4_a, r4_m, r4_p;
    logic [W-1:0] r5_f, r5_p;
    logic [W-1:0] r6_t, r6_a, r6_q, r6_p;
    logic [W-1:0] r7_t, r7_sq, r7_m5, r7_m2, r7_p;
    logic [W-1:0] r8_t, r8_b1, r8_m4, r8_m5, r8_m2, r8_p;
    logic [W-1:0] r9_t, r9_b, r9_a, r9_p;
    logic [W-1:0] r10_t, r10_b, r10_a, r10_p;
    logic [W-1:0] r11_t, r11_den, r11_num;
    logic [W-1:0] r12_t, r12_den, r12_num;
    logic [W-1:0] r13_t, r13_den, r13_dvd;
    logic         r13_two, r13_bad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Temperature terms.
            r1_x <= (adc_t >> 3) - (t1 << 1);
            r1_d <= (adc_t >> 4) - t1;
            r1_p <= adc_p;
            r2_m <= r1_x * t2;
            r2_dd <= r1_d * r1_d;
            r2_p <= r1_p;
            r3_a <= asr(r2_m, 11);
            r3_e <= asr(r2_dd, 12);
            r3_p <= r2_p;
            r4_a <= r3_a;
            r4_m <= r3_e * t3;
            r4_p <= r3_p;
            r5_f <= r4_a + asr(r4_m, 14);
            r5_p <= r4_p;
            // Centidegrees and pressure offset term.
            r6_t <= asr((r5_f << 2) + r5_f + TEMP_ROUND, 8);
            r6_a <= asr(r5_f, 1) - TEMP_OFFSET;
            r6_q <= asr(asr(r5_f, 1) - TEMP_OFFSET, 2);
            r6_p <= r5_p;
            r7_t <= r6_t;
            r7_sq <= r6_q * r6_q;
            r7_m5 <= r6_a * p5;
            r7_m2 <= p2 * r6_a;
            r7_p <= r6_p;
            r8_t <= r7_t;
            r8_b1 <= asr(r7_sq, 11) * p6;
            r8_m4 <= p3 * asr(r7_sq, 13);
            r8_m5 <= r7_m5;
            r8_m2 <= r7_m2;
            r8_p <= r7_p;
            r9_t <= r8_t;
            r9_b <= asr(r8_b1 + (r8_m5 << 1), 2) + (p4 << 16);
            r9_a <= asr(asr(r8_m4, 3) + asr(r8_m2, 1), 18);
            r9_p <= r8_p;
            r10_t <= r9_t;
            r10_b <= r9_b;
            r10_a <= (P1_BIAS + r9_a) * p1;
            r10_p <= r9_p;
            // Denominator and numerator.
            r11_t <= r10_t;
            r11_den <= asr(r10_a, 15);
            r11_num <= (FULL_SCALE - r10_p) - asr(r10_b, 12);
            r12_t <= r11_t;
            r12_den <= r11_den;
            r12_num <= r11_num * PRES_SCALE;
            // Pick the dividend form that keeps the quotient in range.
            r13_t <= r12_t;
            r13_den <= r12_den;
            r13_bad <= (r12_den == '0);
            r13_two <= (r12_num >= HALF_RANGE);
            r13_dvd <= (r12_num >= HALF_RANGE) ? r12_num : (r12_num << 1);
        end
    end

    // Restoring divider, one quotient bit per stage.
    logic [W:0]   r_rem [DIV_STAGES];
    logic [W-1:0] r_quo [DIV_STAGES];
    logic [W-1:0] r_den [DIV_STAGES];
    logic [W-1:0] r_dt  [DIV_STAGES];
    logic         r_two [DIV_STAGES];
    logic         r_bad [DIV_STAGES];

    logic [W:0]   s_in_rem [DIV_STAGES];
    logic [W-1:0] s_in_quo [DIV_STAGES];
    logic [W-1:0] s_in_den [DIV_STAGES];
    logic [W:0]   s_sh     [DIV_STAGES];
    logic         s_ge     [DIV_STAGES];

    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            s_in_rem[k] = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k - 1];
            s_in_quo[k] = (k == 0) ? r13_dvd : r_quo[(k == 0) ? 0 : k - 1];
            s_in_den[k] = (k == 0) ? r13_den : r_den[(k == 0) ? 0 : k - 1];
            s_sh[k]     = {s_in_rem[k][W-1:0], s_in_quo[k][W-1]};
            s_ge[k]     = (s_sh[k] >= {1'b0, s_in_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= s_ge[k] ? s_sh[k] - {1'b0, s_in_den[k]} : s_sh[k];
                r_quo[k] <= {s_in_quo[k][W-2:0], s_ge[k]};
                r_den[k] <= s_in_den[k];
                r_dt[k]  <= (k == 0) ? r13_t   : r_dt[(k == 0) ? 0 : k - 1];
                r_two[k] <= (k == 0) ? r13_two : r_two[(k == 0) ? 0 : k - 1];
                r_bad[k] <= (k == 0) ? r13_bad : r_bad[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Final correction stages.
    logic [W-1:0] r_q1_p, r_q1_t, r_q2_p, r_q2_t, r_q2_ss, r_q2_m8;
    logic [W-1:0] r_q3_p, r_q3_t, r_q3_c1, r_q3_c2;
    logic         r_q1_bad, r_q2_bad, r_q3_bad;
    logic [W-1:0] s1_s, r_o_t, r_o_p;
    logic         r_o_bad;
    assign s1_s = r_q1_p >> 3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1_p   <= r_two[DIV_STAGES-1] ? (r_quo[DIV_STAGES-1] << 1)
                                            : r_quo[DIV_STAGES-1];
            r_q1_t   <= r_dt[DIV_STAGES-1];
            r_q1_bad <= r_bad[DIV_STAGES-1];
            r_q2_ss  <= s1_s * s1_s;
            r_q2_m8  <= (r_q1_p >> 2) * p8;
            r_q2_p   <= r_q1_p;
            r_q2_t   <= r_q1_t;
            r_q2_bad <= r_q1_bad;
            r_q3_c1  <= p9 * (r_q2_ss >> 13);
            r_q3_c2  <= asr(r_q2_m8, 13);
            r_q3_p   <= r_q2_p;
            r_q3_t   <= r_q2_t;
            r_q3_bad <= r_q2_bad;
            // Output register.
            r_o_t   <= r_q3_t;
            r_o_p   <= r_q3_bad ? '0 : r_q3_p + asr(asr(r_q3_c1, 12) + r_q3_c2 + p7, 4);
            r_o_bad <= r_q3_bad;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_o_p, r_o_t};
    assign m_axis_tuser  = r_o_bad;

`ifndef SYNTHESIS
    // An invalid pressure result always carries zero pascals.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[63:32] == '0))
        else $error("invalid pressure result is not zero");
    // A stalled output holds back the input side.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");
    // A result appears only if the last pipeline stage held a valid item.
    a_ov_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_vld[NUM_STAGES-1]))
        else $error("result appeared without a source item");
`endif

endmodule
